/* design/twm_pkg.sv */
// Package: shared types, constants and coil pattern tables for the waypoint mover.
package twm_pkg;

    localparam int QUEUE_DEPTH_DEF = 8;
    localparam int COORD_W         = 10;
    localparam int DWELL_W         = 16;
    localparam int COIL_W          = 4;

    localparam logic [COORD_W-1:0] COORD_MAX         = 10'd999;
    localparam logic [DWELL_W-1:0] PHASE_DWELL_RESET = 16'd2000;

    typedef enum logic
    {
        CMD_PUSH = 1'b0,
        CMD_TICK = 1'b1
    } cmd_t;

    typedef struct packed
    {
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] x;
    } point_t;

    typedef struct packed
    {
        logic push;
        logic pop;
    } q_ctrl_t;

    typedef struct packed
    {
        logic empty;
        logic full;
        logic single;
    } q_status_t;

    function automatic logic [COIL_W-1:0] x_coil(input logic [1:0] ph, input logic up);
        logic [COIL_W-1:0] c;
        case (ph)
            2'd0:    c = up ? 4'd9  : 4'd3;
            2'd1:    c = up ? 4'd12 : 4'd6;
            2'd2:    c = up ? 4'd6  : 4'd12;
            2'd3:    c = up ? 4'd3  : 4'd9;
            default: c = 4'd0;
        endcase
        return c;
    endfunction

    function automatic logic [COIL_W-1:0] y_coil(input logic [1:0] ph, input logic up);
        logic [COIL_W-1:0] c;
        case (ph)
            2'd0:    c = up ? 4'd12 : 4'd10;
            2'd1:    c = up ? 4'd5  : 4'd3;
            2'd2:    c = up ? 4'd3  : 4'd5;
            2'd3:    c = up ? 4'd10 : 4'd12;
            default: c = 4'd0;
        endcase
        return c;
    endfunction

    function automatic logic [COORD_W-1:0] sat_coord(input logic [COORD_W-1:0] v);
        return (v > COORD_MAX) ? COORD_MAX : v;
    endfunction

endpackage

/* design/twm_point_queue.sv */
// Circular queue of target points with head pointer and fill count.
module twm_point_queue #(
    parameter int DEPTH = twm_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  twm_pkg::q_ctrl_t    ctrl,
    input  twm_pkg::point_t     wr_point,
    output twm_pkg::point_t     front,
    output twm_pkg::q_status_t  status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int SUM_W = PTR_W + 1;
    localparam logic [SUM_W-1:0] DEPTH_S = SUM_W'(DEPTH);
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);
    localparam logic [PTR_W-1:0] LAST_P  = PTR_W'(DEPTH - 1);

    twm_pkg::point_t  mem [DEPTH];
    twm_pkg::point_t  front_reg;
    logic [PTR_W-1:0] head_reg, head_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [SUM_W-1:0] tail_sum;
    logic [PTR_W-1:0] tail;

    // count < DEPTH on a write, so head + count stays below twice the depth
    always_comb
    begin
        tail_sum = SUM_W'(head_reg) + SUM_W'(count_reg);
        if (tail_sum >= DEPTH_S)
        begin
            tail_sum = tail_sum - DEPTH_S;
        end
        tail = tail_sum[PTR_W-1:0];
    end

    always_comb
    begin
        head_next  = head_reg;
        count_next = count_reg;
        if (ctrl.pop)
        begin
            head_next  = (head_reg == LAST_P) ? '0 : head_reg + 1'b1;
            count_next = count_next - 1'b1;
        end
        if (ctrl.push)
        begin
            count_next = count_next + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            count_reg <= count_next;
        end
    end

    // front_reg tracks the entry at the next head; a write into that slot is forwarded
    always_ff @(posedge clk)
    begin
        if (ctrl.push)
        begin
            mem[tail] <= wr_point;
        end
        if (ctrl.push && (tail == head_next))
        begin
            front_reg <= wr_point;
        end
        else
        begin
            front_reg <= mem[head_next];
        end
    end

    assign front         = front_reg;
    assign status.empty  = (count_reg == '0);
    assign status.full   = (count_reg == DEPTH_C);
    assign status.single = (count_reg == CNT_W'(1));

endmodule

/* design/two_axis_stepper_waypoint_mover_top.sv */
// Top level: two-axis stepper waypoint mover with point queue and result register.
// Each accepted input beat yields its result beat directly in the output register.
// Throughput: one input beat per cycle; s_tready stays high while the result is taken or absent.
// Each tick with a point queued either pops a reached point or advances the dwell counter and at most one coil phase.
// Reset: positions, queue pointers, phase, dwell and coils cleared; phase_dwell set to 2000.
// Queue entries hold no reset value and are read only after being written.
module two_axis_stepper_waypoint_mover_top #(
    parameter int QUEUE_DEPTH = twm_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    // configuration: phase_dwell
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data,
    // input beats
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // target_x[9:0], target_y[19:10], zero pad
    input  logic        s_tuser,   // command
    // result beats
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // x_coils[3:0], y_coils[7:4], pos_x[17:8], pos_y[27:18],
                                   // busy_res[28], push_rejected[29], zero pad
);

    localparam int CW = twm_pkg::COORD_W;
    localparam int DW = twm_pkg::DWELL_W;
    localparam int KW = twm_pkg::COIL_W;

    logic [DW-1:0] phase_dwell_reg;
    logic [CW-1:0] cur_x_reg, cur_x_next;
    logic [CW-1:0] cur_y_reg, cur_y_next;
    logic          moving_y_reg, moving_y_next;
    logic [1:0]    phase_reg, phase_next;
    logic [DW-1:0] dwell_reg, dwell_next;
    logic [KW-1:0] x_drive_reg, x_drive_next;
    logic [KW-1:0] y_drive_reg, y_drive_next;
    logic          m_valid_reg;
    logic [31:0]   m_data_reg, m_data_next;

    logic               accept;
    twm_pkg::cmd_t      cmd;
    twm_pkg::point_t    push_point;
    twm_pkg::point_t    front;
    twm_pkg::q_ctrl_t   q_ctrl;
    twm_pkg::q_status_t q_status;

    logic          on_y;
    logic [CW-1:0] pos_sel, tgt_sel, pos_new;
    logic          up;
    logic [DW-1:0] dwell_inc, limit;
    logic          rejected, busy_next;

    assign cfg_ready = 1'b1;
    assign s_tready  = !m_valid_reg || m_tready;
    assign accept    = s_tvalid && s_tready;
    assign cmd       = twm_pkg::cmd_t'(s_tuser);

    assign push_point.x = twm_pkg::sat_coord(s_tdata[CW-1:0]);
    assign push_point.y = twm_pkg::sat_coord(s_tdata[2*CW-1:CW]);

    twm_point_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (q_ctrl),
        .wr_point (push_point),
        .front    (front),
        .status   (q_status)
    );

    always_comb
    begin
        q_ctrl       = '0;
        cur_x_next   = cur_x_reg;
        cur_y_next   = cur_y_reg;
        moving_y_next = moving_y_reg;
        phase_next   = phase_reg;
        dwell_next   = dwell_reg;
        x_drive_next = x_drive_reg;
        y_drive_next = y_drive_reg;
        rejected     = 1'b0;
        busy_next    = !q_status.empty;

        on_y      = moving_y_reg || (cur_x_reg == front.x);
        pos_sel   = on_y ? cur_y_reg : cur_x_reg;
        tgt_sel   = on_y ? front.y : front.x;
        up        = tgt_sel > pos_sel;
        dwell_inc = dwell_reg + 1'b1;
        limit     = (phase_dwell_reg == '0) ? DW'(1) : phase_dwell_reg;
        pos_new   = pos_sel;

        case (cmd)
            twm_pkg::CMD_PUSH:
            begin
                if (q_status.full)
                begin
                    rejected = 1'b1;
                end
                else
                begin
                    q_ctrl.push = accept;
                    busy_next   = 1'b1;
                end
            end
            twm_pkg::CMD_TICK:
            begin
                if (!q_status.empty)
                begin
                    moving_y_next = on_y;
                    if (on_y && (cur_y_reg == front.y))
                    begin
                        q_ctrl.pop    = accept;
                        busy_next     = !q_status.single;
                        moving_y_next = 1'b0;
                        phase_next    = '0;
                        dwell_next    = '0;
                    end
                    else
                    begin
                        if (dwell_reg == '0)
                        begin
                            if (on_y)
                            begin
                                y_drive_next = twm_pkg::y_coil(phase_reg, up);
                            end
                            else
                            begin
                                x_drive_next = twm_pkg::x_coil(phase_reg, up);
                            end
                        end
                        if (dwell_inc >= limit)
                        begin
                            dwell_next = '0;
                            if (phase_reg == 2'd3)
                            begin
                                phase_next = '0;
                                if (up)
                                begin
                                    pos_new = pos_sel + 1'b1;
                                end
                                else if (pos_sel != '0)
                                begin
                                    pos_new = pos_sel - 1'b1;
                                end
                            end
                            else
                            begin
                                phase_next = phase_reg + 1'b1;
                            end
                        end
                        else
                        begin
                            dwell_next = dwell_inc;
                        end
                        if (on_y)
                        begin
                            cur_y_next = pos_new;
                        end
                        else
                        begin
                            cur_x_next = pos_new;
                        end
                    end
                end
            end
            default:
            begin
                rejected = 1'b0;
            end
        endcase

        m_data_next = {2'b00, rejected, busy_next, cur_y_next, cur_x_next,
                       y_drive_next, x_drive_next};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_dwell_reg <= twm_pkg::PHASE_DWELL_RESET;
            cur_x_reg       <= '0;
            cur_y_reg       <= '0;
            moving_y_reg    <= 1'b0;
            phase_reg       <= '0;
            dwell_reg       <= '0;
            x_drive_reg     <= '0;
            y_drive_reg     <= '0;
            m_valid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                phase_dwell_reg <= cfg_data;
            end
            if (accept)
            begin
                cur_x_reg    <= cur_x_next;
                cur_y_reg    <= cur_y_next;
                moving_y_reg <= moving_y_next;
                phase_reg    <= phase_next;
                dwell_reg    <= dwell_next;
                x_drive_reg  <= x_drive_next;
                y_drive_reg  <= y_drive_next;
                m_valid_reg  <= 1'b1;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

/* verif/two_axis_stepper_waypoint_mover_top_tb.sv */
// Self-checking testbench for the two-axis stepper waypoint mover.
`timescale 1ns / 1ps

module two_axis_stepper_waypoint_mover_top_tb;

    localparam int MOVER_DEPTH = 8;

    // phase 0 in the lowest nibble
    localparam logic [15:0] X_FWD_SEQ = {4'd3, 4'd6, 4'd12, 4'd9};
    localparam logic [15:0] X_REV_SEQ = {4'd9, 4'd12, 4'd6, 4'd3};
    localparam logic [15:0] Y_FWD_SEQ = {4'd10, 4'd3, 4'd5, 4'd12};
    localparam logic [15:0] Y_REV_SEQ = {4'd12, 4'd5, 4'd3, 4'd10};

    // packed in m_tdata order, lowest field last
    typedef struct packed
    {
        logic       rej;
        logic       busy;
        logic [9:0] py;
        logic [9:0] px;
        logic [3:0] yc;
        logic [3:0] xc;
    } mover_status_t;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [15:0] cfg_data  = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata   = '0;   // target_x[9:0], target_y[19:10], zero pad
    logic        s_tuser   = 1'b0; // command
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [31:0] m_tdata;          // x_coils[3:0], y_coils[7:4], pos_x[17:8], pos_y[27:18],
                                   // busy_res[28], push_rejected[29], zero pad

    // predicted mover state
    logic [15:0]     dwell_cfg = twm_pkg::PHASE_DWELL_RESET;
    logic [9:0]      at_x = '0;
    logic [9:0]      at_y = '0;
    twm_pkg::point_t pt_store [MOVER_DEPTH];
    logic [2:0]      pt_head = '0;
    logic [3:0]      pt_count = '0;
    logic            on_y_axis = 1'b0;
    logic [1:0]      coil_phase = '0;
    logic [15:0]     dwell_ticks = '0;
    logic [3:0]      x_pattern = '0;
    logic [3:0]      y_pattern = '0;
    twm_pkg::point_t last_pt = '0;

    mover_status_t expected_status [$];
    int          errors = 0;
    bit          quiet_mode = 1'b0;
    int          stall_left = 0;

    two_axis_stepper_waypoint_mover_top #(
        .QUEUE_DEPTH (MOVER_DEPTH)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #4 clk = ~clk;

    initial
    begin
        #40_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    // one tick of a unit step on the active axis
    task automatic step_motor(input logic up, input logic [15:0] fwd, input logic [15:0] rev,
                              inout logic [9:0] pos, inout logic [3:0] pattern);
        logic [15:0] limit;
        limit = (dwell_cfg == 16'd0) ? 16'd1 : dwell_cfg;
        if (dwell_ticks == 16'd0)
            pattern = up ? fwd[{coil_phase, 2'b00} +: 4] : rev[{coil_phase, 2'b00} +: 4];
        dwell_ticks = dwell_ticks + 16'd1;
        if (dwell_ticks >= limit)
        begin
            dwell_ticks = '0;
            if (coil_phase == 2'd3)
            begin
                if (up)
                    pos = pos + 10'd1;
                else if (pos != 10'd0)
                    pos = pos - 10'd1;
            end
            coil_phase = coil_phase + 2'd1;
        end
    endtask

    task automatic predict_status(input twm_pkg::cmd_t cmd, input logic [9:0] tx,
                                  input logic [9:0] ty);
        mover_status_t   want;
        twm_pkg::point_t head;
        logic [2:0]      slot;
        logic            rejected;
        rejected = 1'b0;
        if (cmd == twm_pkg::CMD_PUSH)
        begin
            if (pt_count >= MOVER_DEPTH)
                rejected = 1'b1;
            else
            begin
                last_pt.x = (tx > twm_pkg::COORD_MAX) ? twm_pkg::COORD_MAX : tx;
                last_pt.y = (ty > twm_pkg::COORD_MAX) ? twm_pkg::COORD_MAX : ty;
                slot = pt_head + pt_count[2:0];
                pt_store[slot] = last_pt;
                pt_count = pt_count + 4'd1;
            end
        end
        else if (pt_count != 4'd0)
        begin
            head = pt_store[pt_head];
            if (!on_y_axis && at_x == head.x)
                on_y_axis = 1'b1;
            if (on_y_axis && at_y == head.y)
            begin
                pt_head     = pt_head + 3'd1;
                pt_count    = pt_count - 4'd1;
                on_y_axis   = 1'b0;
                coil_phase  = '0;
                dwell_ticks = '0;
            end
            else if (!on_y_axis)
                step_motor(head.x > at_x, X_FWD_SEQ, X_REV_SEQ, at_x, x_pattern);
            else
                step_motor(head.y > at_y, Y_FWD_SEQ, Y_REV_SEQ, at_y, y_pattern);
        end
        want.xc   = x_pattern;
        want.yc   = y_pattern;
        want.px   = at_x;
        want.py   = at_y;
        want.busy = (pt_count != 4'd0);
        want.rej  = rejected;
        expected_status.push_back(want);
    endtask

    // called at a falling edge; returns at the falling edge after the beat, tvalid still high
    task automatic send_item(input twm_pkg::cmd_t cmd, input logic [9:0] tx,
                             input logic [9:0] ty);
        int gap;
        int roll;
        gap  = 0;
        roll = $urandom_range(0, 99);
        if (!quiet_mode)
        begin
            if (roll >= 96)
                gap = $urandom_range(8, 30);
            else if (roll >= 60)
                gap = $urandom_range(1, 3);
        end
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {4'b0000, ty, tx};
        do
        begin
            @(posedge clk);
        end
        while (!s_tready);
        predict_status(cmd, tx, ty);
        @(negedge clk);
    endtask

    task automatic send_tick();
        send_item(twm_pkg::CMD_TICK, 10'($urandom_range(0, 1023)),
                  10'($urandom_range(0, 1023)));
    endtask

    // block must be idle: every result in before the write
    task automatic write_dwell(input logic [15:0] value);
        s_tvalid <= 1'b0;
        while (expected_status.size() != 0)
            @(negedge clk);
        repeat (2) @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        dwell_cfg = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic check_field(input string what, input logic [9:0] want, input logic [9:0] seen);
        if (seen !== want)
        begin
            errors++;
            if (errors <= 40)
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, seen);
        end
    endtask

    always @(posedge clk)
    begin : result_check
        mover_status_t seen;
        mover_status_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            seen = mover_status_t'(m_tdata[29:0]);
            if (expected_status.size() == 0)
            begin
                errors++;
                if (errors <= 40)
                    $display("%0t: result beat with none expected, expected none, actual %h",
                             $time, m_tdata);
            end
            else
            begin
                want = expected_status.pop_front();
                check_field("x_coils", 10'(want.xc), 10'(seen.xc));
                check_field("y_coils", 10'(want.yc), 10'(seen.yc));
                check_field("pos_x", want.px, seen.px);
                check_field("pos_y", want.py, seen.py);
                check_field("busy_res", 10'(want.busy), 10'(seen.busy));
                check_field("push_rejected", 10'(want.rej), 10'(seen.rej));
            end
        end
    end

    always @(negedge clk)
    begin : result_sink
        int roll;
        if (rst_n)
        begin
            if (quiet_mode)
            begin
                stall_left = 0;
                m_tready <= 1'b1;
            end
            else if (stall_left != 0)
            begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else
            begin
                roll = $urandom_range(0, 99);
                if (roll < 70)
                    m_tready <= 1'b1;
                else
                begin
                    m_tready <= 1'b0;
                    stall_left = (roll < 97) ? $urandom_range(0, 3) : $urandom_range(10, 40);
                end
            end
        end
    end

    // empty queue tick, then a point already reached
    task automatic test_idle_and_reached();
        send_item(twm_pkg::CMD_TICK, 10'h3FF, 10'h3FF);
        send_item(twm_pkg::CMD_PUSH, 10'd0, 10'd0);
        send_item(twm_pkg::CMD_TICK, 10'd0, 10'd0);
    endtask

    // reset dwell of 2000 holds the first pattern
    task automatic test_reset_dwell();
        send_item(twm_pkg::CMD_PUSH, 10'd1, 10'd1);
        repeat (3) send_tick();
    endtask

    // zero dwell, points queued in both directions on both axes, then a push into a full queue
    task automatic test_queue_full();
        write_dwell(16'd0);
        send_item(twm_pkg::CMD_PUSH, 10'd0, 10'd1);
        send_item(twm_pkg::CMD_PUSH, 10'd0, 10'd0);
        send_item(twm_pkg::CMD_PUSH, 10'd1, 10'd0);
        send_item(twm_pkg::CMD_PUSH, 10'd1, 10'd1);
        send_item(twm_pkg::CMD_PUSH, 10'd1, 10'd1);
        send_item(twm_pkg::CMD_PUSH, 10'd0, 10'd0);
        send_item(twm_pkg::CMD_PUSH, 10'd2, 10'd0);
        send_item(twm_pkg::CMD_PUSH, 10'h3FF, 10'h3FF);
    endtask

    // drain the queue, then a saturated push to the far corner and the start of the haul
    task automatic test_far_corner();
        write_dwell(16'd1);
        quiet_mode = 1'b1;
        while (pt_count != 4'd0)
            send_tick();
        send_item(twm_pkg::CMD_PUSH, 10'h3FF, 10'h3FF);
        repeat (40) send_tick();
        quiet_mode = 1'b0;
    endtask

    // short hops near the last queued point; noise only into a full queue
    task automatic test_random_walk(input logic [15:0] dwell, input int n_items,
                                    input int push_pct, input bit calm);
        int k;
        int tx;
        int ty;
        write_dwell(dwell);
        quiet_mode = calm;
        for (k = 0; k < n_items; k++)
        begin
            if (pt_count < MOVER_DEPTH && $urandom_range(0, 99) < push_pct)
            begin
                tx = int'(last_pt.x) + int'($urandom_range(0, 10)) - 5;
                ty = int'(last_pt.y) + int'($urandom_range(0, 10)) - 5;
                if ($urandom_range(0, 5) == 0)
                    tx = int'(last_pt.x);
                if ($urandom_range(0, 7) == 0)
                    ty = int'(last_pt.y);
                tx = (tx < 0) ? 0 : (tx > 1023) ? 1023 : tx;
                ty = (ty < 0) ? 0 : (ty > 1023) ? 1023 : ty;
                send_item(twm_pkg::CMD_PUSH, tx[9:0], ty[9:0]);
            end
            else if (pt_count == MOVER_DEPTH && $urandom_range(0, 99) < 5)
                send_item(twm_pkg::CMD_PUSH, 10'($urandom_range(0, 1023)),
                          10'($urandom_range(0, 1023)));
            else
                send_tick();
        end
        quiet_mode = 1'b0;
    endtask

    initial
    begin : main
        int waited;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_idle_and_reached();
        test_reset_dwell();
        test_queue_full();
        test_random_walk(16'd1, 300, 12, 1'b0);
        test_random_walk(16'd2, 150, 8, 1'b1);
        test_random_walk(16'd0, 250, 15, 1'b0);
        test_random_walk(16'd3, 250, 6, 1'b0);
        test_random_walk(16'hFFFF, 40, 30, 1'b0);
        test_random_walk(16'd1, 150, 20, 1'b0);
        test_far_corner();

        s_tvalid <= 1'b0;
        waited = 0;
        while (expected_status.size() != 0 && waited < 20000)
        begin
            @(posedge clk);
            waited++;
        end
        if (expected_status.size() != 0)
        begin
            errors++;
            $display("%0t: results outstanding, expected 0, actual %0d",
                     $time, expected_status.size());
        end
        repeat (4) @(posedge clk);
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
